@@ rtl/rmiirx_pkg.sv @@
// rmiirx_pkg: shared types, result codes and helpers for the RMII receive deframer.
// No dependencies; imported by the deframer and its checker.
package rmiirx_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_HUNT = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // result kind carried on tuser
  localparam logic KIND_SFD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [7:0] SFD_RESET   = 8'hD5;
  localparam int         IN_TDATA_W  = 8;
  localparam int         OUT_TDATA_W = 8;

  // newest dibit enters at bits 7:6, older ones move down
  function automatic logic [7:0] shift_in(input logic [7:0] cur, input logic [1:0] dibit);
    shift_in = {dibit, cur[7:2]};
  endfunction

endpackage

@@ rtl/rmii_receive_deframer.sv @@
// Results are registered: a result appears on out_* in the cycle after the sample beat that completes it.
// Throughput: one sample beat per cycle; in_tready drops only while a result is held
// in the output register and out_tready is low.
// Reset (rst_n low, synchronous): phase idle, counters and carrier history cleared,
// output register emptied, sfd_pattern back to 0xD5.
// rmii_receive_deframer: top level; depends on rmiirx_pkg.
module rmii_receive_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rmiirx_pkg::IN_TDATA_W-1:0]   in_tdata,   // [0] crs_dv, [1] rxd0, [2] rxd1
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rmiirx_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] byte_value
  output logic                                out_tuser,  // [0] item_kind
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [7:0]                          cfg_wr_data // [7:0] sfd_pattern
);
  import rmiirx_pkg::*;

  // deframer state
  phase_t     phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [1:0] count_r, count_nxt;
  logic       low_run_r, low_run_nxt;
  logic       last_crs_r, last_crs_nxt;
  logic [7:0] sfd_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_kind_r, out_kind_nxt;

  logic       accept;
  logic       crs;
  logic [1:0] dibit;
  logic [7:0] shifted;
  logic       emit;
  logic       emit_kind;

  // a sample may enter whenever the output register is empty or draining this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign crs     = in_tdata[0];
  assign dibit   = in_tdata[2:1];
  assign shifted = shift_in(shift_r, dibit);

  // per-sample deframing step
  always_comb begin
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    count_nxt    = count_r;
    low_run_nxt  = low_run_r;
    last_crs_nxt = last_crs_r;
    emit         = 1'b0;
    emit_kind    = KIND_DATA;
    if (accept) begin
      last_crs_nxt = crs;
      case (phase_r)
        PH_IDLE: begin
          // a rising carrier is itself the first sample of the nonzero-dibit wait
          if (crs && !last_crs_r) begin
            if (dibit != 2'b00) begin
              shift_nxt = {dibit, 6'b0};
              phase_nxt = PH_HUNT;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          if (!crs) begin
            phase_nxt = PH_IDLE;
          end else if (dibit != 2'b00) begin
            shift_nxt = {dibit, 6'b0};
            phase_nxt = PH_HUNT;
          end
        end
        PH_HUNT: begin
          if (!crs) begin
            phase_nxt = PH_IDLE;
          end else begin
            shift_nxt = shifted;
            if (shifted == sfd_r) begin
              emit        = 1'b1;
              emit_kind   = KIND_SFD;
              phase_nxt   = PH_DATA;
              count_nxt   = 2'd0;
              low_run_nxt = 1'b0;
            end
          end
        end
        PH_DATA: begin
          if (!crs && low_run_r) begin
            // second low sample in a row: frame over, partial byte dropped
            phase_nxt   = PH_IDLE;
            low_run_nxt = 1'b0;
            count_nxt   = 2'd0;
          end else begin
            low_run_nxt = !crs;
            shift_nxt   = shifted;
            if (count_r == 2'd3) begin
              emit      = 1'b1;
              emit_kind = KIND_DATA;
              count_nxt = 2'd0;
            end else begin
              count_nxt = count_r + 2'd1;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // output register: load on a result, empty once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = shifted;
      out_kind_nxt  = emit_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= 8'd0;
      count_r     <= 2'd0;
      low_run_r   <= 1'b0;
      last_crs_r  <= 1'b0;
      sfd_r       <= SFD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      count_r     <= count_nxt;
      low_run_r   <= low_run_nxt;
      last_crs_r  <= last_crs_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        sfd_r <= cfg_wr_data;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;

endmodule

@@ rtl/rmiirx_chk.sv @@
// rmiirx_chk: port-level checks on the RMII receive deframer, bound to the top level.
// Depends on rmiirx_pkg and rmii_receive_deframer.
module rmiirx_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [rmiirx_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rmiirx_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                                out_tuser
);
  import rmiirx_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with nothing pending the sample side never stalls
  a_ready_when_empty: assert property (@(posedge clk) !out_tvalid |-> in_tready)
    else $error("sample stalled with empty output");

  // a new result only follows an accepted sample beat
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without a sample beat");

  // a delimiter beat comes from a sample with carrier high, or is one still held
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SFD |-> $past(in_tvalid && in_tready && in_tdata[0])
      || $past(out_tvalid && !out_tready))
    else $error("delimiter without carrier");

endmodule

bind rmii_receive_deframer rmiirx_chk u_rmiirx_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .in_tdata    (in_tdata),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tuser   (out_tuser)
);
